// ===== src/mncd_pkg.sv =====
// Shared types, constants and the pitch table of the melody note code decoder.
package mncd_pkg;

   // Configuration port geometry and register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_WHOLE_NOTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_RATIO  = 2'd1;

   // Register reset values
   localparam logic [15:0] WHOLE_NOTE_RESET = 16'd2000;
   localparam logic [7:0]  GAP_RATIO_RESET  = 8'd77;

   // Pitch index that marks a rest
   localparam logic [3:0] REST_INDEX = 4'd12;
   // Octave used when the octave character is not a digit 1..7
   localparam logic [2:0] DEFAULT_OCTAVE = 3'd4;

   // One decoded note handed from front to back
   typedef struct packed {
      logic [3:0] note_index;
      logic [3:0] length_shift;
      logic [2:0] octave;
   } cmd_type;

   // Command beat with its valid flag
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_beat_type;

   // Octave-4 pitches in unsigned Q15
   function automatic logic [23:0] pitch_q15(input logic [3:0] idx);
      logic [23:0] p;
      unique case (idx)
         4'd0:    p = 24'd8572961;
         4'd1:    p = 24'd9082733;
         4'd2:    p = 24'd9622815;
         4'd3:    p = 24'd10195010;
         4'd4:    p = 24'd10801250;
         4'd5:    p = 24'd11443503;
         4'd6:    p = 24'd12123963;
         4'd7:    p = 24'd12844892;
         4'd8:    p = 24'd13608714;
         4'd9:    p = 24'd14417920;
         4'd10:   p = 24'd15275262;
         4'd11:   p = 24'd16183558;
         default: p = 24'd0;
      endcase
      return p;
   endfunction

endpackage

// ===== src/mncd_req_if.sv =====
// Input channel of the decoder: one melody code character per beat.
interface mncd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_char;
   logic       melody_start;

   modport source (output valid, output code_char, output melody_start, input ready);
   modport sink   (input valid, input code_char, input melody_start, output ready);
endinterface

// ===== src/mncd_rsp_if.sv =====
// Result channel of the decoder: one note per beat.
interface mncd_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] frequency_hz;
   logic [15:0] tone_ms;
   logic [16:0] slot_ms;

   modport source (output valid, output frequency_hz, output tone_ms, output slot_ms,
                   input ready);
   modport sink   (input valid, input frequency_hz, input tone_ms, input slot_ms,
                   output ready);
endinterface

// ===== src/mncd_front.sv =====
// Front end: tracks the group position and classifies code characters.
module mncd_front (
   input  logic                  clock,
   input  logic                  reset,
   mncd_req_if.sink              req_bus,
   input  logic                  queue_full,
   output mncd_pkg::cmd_beat_type push
);
   import mncd_pkg::*;

   logic [1:0] group_position_ff, group_position_in;
   logic [3:0] held_length_shift_ff, held_length_shift_in;
   logic [3:0] held_note_index_ff, held_note_index_in;
   logic [1:0] pos;
   logic       accept;

   // Length code to shift; unknown codes mean a whole note
   function automatic logic [3:0] length_shift_of(input logic [7:0] c);
      logic [3:0] s;
      unique case (c)
         "2":     s = 4'd1;
         "4":     s = 4'd2;
         "8":     s = 4'd3;
         "f":     s = 4'd4;
         "g":     s = 4'd5;
         "h":     s = 4'd6;
         "i":     s = 4'd7;
         "j":     s = 4'd8;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   // Note letter to pitch index; unknown letters are rests
   function automatic logic [3:0] note_index_of(input logic [7:0] c);
      logic [3:0] n;
      unique case (c)
         "C":     n = 4'd0;
         "d":     n = 4'd1;
         "D":     n = 4'd2;
         "e":     n = 4'd3;
         "E":     n = 4'd4;
         "F":     n = 4'd5;
         "g":     n = 4'd6;
         "G":     n = 4'd7;
         "a":     n = 4'd8;
         "A":     n = 4'd9;
         "b":     n = 4'd10;
         "B":     n = 4'd11;
         default: n = REST_INDEX;
      endcase
      return n;
   endfunction

   // Octave digit; anything outside 1..7 falls back to octave 4
   function automatic logic [2:0] octave_of(input logic [7:0] c);
      logic [2:0] o;
      if (c >= "1" && c <= "7") begin
         o = 3'(c - "0");
      end else begin
         o = DEFAULT_OCTAVE;
      end
      return o;
   endfunction

   assign req_bus.ready = !queue_full;
   assign accept = req_bus.valid && req_bus.ready;
   assign pos    = req_bus.melody_start ? 2'd0 : group_position_ff;

   // Next-state and command push
   always_comb begin
      group_position_in    = group_position_ff;
      held_length_shift_in = held_length_shift_ff;
      held_note_index_in   = held_note_index_ff;
      push.valid           = 1'b0;
      push.cmd.note_index   = held_note_index_ff;
      push.cmd.length_shift = held_length_shift_ff;
      push.cmd.octave       = octave_of(req_bus.code_char);
      if (accept) begin
         group_position_in = pos + 2'd1;
         unique case (pos)
            2'd0: held_length_shift_in = length_shift_of(req_bus.code_char);
            2'd1: held_note_index_in   = note_index_of(req_bus.code_char);
            2'd2: push.valid           = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_position_ff    <= 2'd0;
         held_length_shift_ff <= 4'd0;
         held_note_index_ff   <= REST_INDEX;
      end else begin
         group_position_ff    <= group_position_in;
         held_length_shift_ff <= held_length_shift_in;
         held_note_index_ff   <= held_note_index_in;
      end
   end

endmodule

// ===== src/mncd_queue.sv =====
// Short command queue between front and back end.
module mncd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mncd_pkg::cmd_beat_type push,
   output logic                  full,
   output mncd_pkg::cmd_beat_type head,
   input  logic                  pop
);
   import mncd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ===== src/mncd_back.sv =====
// Back end: turns a decoded note into frequency and durations.
module mncd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mncd_pkg::cmd_beat_type head,
   output logic                  pop,
   input  logic [15:0]           whole_note_ms,
   input  logic [7:0]            gap_ratio_q8,
   mncd_rsp_if.source            rsp_bus
);
   import mncd_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] frequency_hz_ff;
   logic [15:0] tone_ms_ff;
   logic [16:0] slot_ms_ff;

   logic [4:0]  shift;
   logic [24:0] rounded;
   logic [24:0] scaled;
   logic [11:0] frequency;
   logic [15:0] tone;
   logic [8:0]  gain;
   logic [24:0] product;
   logic        load;

   // Frequency: Q15 pitch scaled by 2^(octave-4), rounded half up
   always_comb begin
      shift   = 5'd19 - {2'b00, head.cmd.octave};
      rounded = {1'b0, pitch_q15(head.cmd.note_index)} + (25'd1 << (shift - 5'd1));
      scaled  = rounded >> shift;
      frequency = (head.cmd.note_index >= REST_INDEX) ? 12'd0 : scaled[11:0];
   end

   // Tone and slot time
   assign tone    = whole_note_ms >> head.cmd.length_shift;
   assign gain    = {1'b1, gap_ratio_q8};
   assign product = {9'd0, tone} * {16'd0, gain};

   assign load = head.valid && (!rsp_valid_ff || rsp_bus.ready);
   assign pop  = load;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         frequency_hz_ff <= frequency;
         tone_ms_ff      <= tone;
         slot_ms_ff      <= product[24:8];
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.frequency_hz = frequency_hz_ff;
   assign rsp_bus.tone_ms      = tone_ms_ff;
   assign rsp_bus.slot_ms      = slot_ms_ff;

endmodule

// ===== src/melody_note_code_decoder_core.sv =====
// A note is queued when its octave digit beat is accepted, then registered onto rsp.
// Throughput: one code character per cycle; the command queue and the output
// register let front and back stall apart, so a full queue holds off req.
// Reset (synchronous, active high) clears the group position, sets the held note
// to a rest, empties the queue and restores whole_note_ms 2000 and gap ratio 77.
module melody_note_code_decoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   mncd_req_if.sink                        req_bus,
   mncd_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [mncd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mncd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mncd_pkg::*;

   logic [15:0]  whole_note_ms_ff, whole_note_ms_in;
   logic [7:0]   gap_ratio_q8_ff, gap_ratio_q8_in;
   cmd_beat_type push;
   cmd_beat_type head;
   logic         queue_full;
   logic         pop;

   // Configuration registers
   always_comb begin
      whole_note_ms_in = whole_note_ms_ff;
      gap_ratio_q8_in  = gap_ratio_q8_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WHOLE_NOTE: whole_note_ms_in = csr_wdata;
            CSR_GAP_RATIO:  gap_ratio_q8_in  = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_note_ms_ff <= WHOLE_NOTE_RESET;
         gap_ratio_q8_ff  <= GAP_RATIO_RESET;
      end else begin
         whole_note_ms_ff <= whole_note_ms_in;
         gap_ratio_q8_ff  <= gap_ratio_q8_in;
      end
   end

   mncd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push)
   );

   mncd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   mncd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .whole_note_ms (whole_note_ms_ff),
      .gap_ratio_q8  (gap_ratio_q8_ff),
      .rsp_bus       (rsp_bus)
   );

endmodule
